>>> hdl/dmsu_pkg.sv
// Shared types, constants and elaboration-time tables for the stencil update block.
package dmsu_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int WORD_W    = 32;
	localparam int EXP_W     = 37;   // e^r / e^-r width, Q30 signed
	localparam int K_W       = 8;    // signed exponent of two, |k| <= 46
	localparam int CQ        = 30;   // CORDIC fraction bits
	localparam int MAX_ITERS = 32;

	localparam longint LN2_Q30  = 744261118;
	localparam longint LN2_HALF = 372130559;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADVECTION   = 2'd0,
		CFG_DIFFUSION   = 2'd1,
		CFG_INV_TEMP    = 2'd2,
		CFG_REACTION    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_SAT    = 2'd1,
		ST_NONPOS = 2'd2
	} status_t;

	typedef logic [5:0]  sh_tab_t [MAX_ITERS];
	typedef logic [30:0] at_tab_t [MAX_ITERS];

	// shift sequence 1,2,3,4,4,5,...,13,13,14,... (repeats at 4, 13, 40)
	function automatic sh_tab_t hyp_shift_tab();
		sh_tab_t     t;
		int unsigned idx;
		int unsigned rep_at;
		bit          rep_done;
		idx      = 1;
		rep_at   = 4;
		rep_done = 1'b0;
		for (int n = 0; n < MAX_ITERS; n++) begin
			t[n] = 6'(idx);
			if (idx == rep_at && !rep_done) begin
				rep_done = 1'b1;
			end else begin
				if (idx == rep_at) begin
					rep_at   = 3 * rep_at + 1;
					rep_done = 1'b0;
				end
				idx++;
			end
		end
		return t;
	endfunction

	// unsigned quotient by shift and subtract, used for table setup only
	function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r    = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// atanh(2^-i) in Q30 from the odd power series in Q62
	function automatic longint unsigned atanh_q30(int unsigned i);
		longint unsigned sum;
		sum = 0;
		for (int unsigned n = 1; i * n <= 62; n += 2)
			sum += udiv64(64'd1 << (62 - i * n), 64'(n));
		return (sum + (64'd1 << 31)) >> 32;
	endfunction

	function automatic at_tab_t hyp_atanh_tab();
		at_tab_t t;
		sh_tab_t s;
		s = hyp_shift_tab();
		for (int n = 0; n < MAX_ITERS; n++)
			t[n] = 31'(atanh_q30(int'(s[n])));
		return t;
	endfunction

	function automatic longint unsigned isqrt64(longint unsigned v);
		longint unsigned res;
		longint unsigned bit_v;
		longint unsigned rem;
		res   = 0;
		rem   = v;
		bit_v = 64'd1 << 62;
		while (bit_v > rem)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	// 1/K start value in Q30 for a given iteration count
	function automatic longint unsigned hyp_x0(int iters);
		longint unsigned p;
		sh_tab_t         s;
		p = 64'd1 << 62;
		s = hyp_shift_tab();
		for (int n = 0; n < iters; n++)
			p = p - (p >> (2 * int'(s[n])));
		return udiv64(64'd1 << 61, isqrt64(p));
	endfunction

endpackage

>>> hdl/dmsu_phi_div.sv
// Pipelined restoring divider: phi = B*m / rho, truncated, clamped to +-32.
module dmsu_phi_div #(
	parameter int FRAC_BITS = 20
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [62:0]                 num_mag,
	input  logic                        num_neg,
	input  logic [30:0]                 dvs,
	output logic signed [FRAC_BITS+6:0] phi
);
	localparam int DQ = FRAC_BITS + 6;
	localparam int CW = ((31 + DQ > 63) ? 31 + DQ : 63) + 1;
	localparam logic [DQ-1:0] LIM = DQ'(1) << (FRAC_BITS + 5);

	logic [CW-1:0] rem_s [DQ+1];
	logic [DQ-1:0] q_s   [DQ+1];
	logic [30:0]   dvs_s [DQ+1];
	logic          ovf_s [DQ+1];
	logic          neg_s [DQ+1];
	logic [DQ-1:0] mag;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(num_mag);
			ovf_s[0] <= CW'(num_mag) >= (CW'(dvs) << DQ);
			neg_s[0] <= num_neg;
			dvs_s[0] <= dvs;
			q_s[0]   <= '0;
			for (int j = 1; j <= DQ; j++) begin
				if (rem_s[j-1] >= (CW'(dvs_s[j-1]) << (DQ - j))) begin
					rem_s[j] <= rem_s[j-1] - (CW'(dvs_s[j-1]) << (DQ - j));
					q_s[j]   <= q_s[j-1] | (DQ'(1) << (DQ - j));
				end else begin
					rem_s[j] <= rem_s[j-1];
					q_s[j]   <= q_s[j-1];
				end
				ovf_s[j] <= ovf_s[j-1];
				neg_s[j] <= neg_s[j-1];
				dvs_s[j] <= dvs_s[j-1];
			end
		end
	end

	assign mag = (ovf_s[DQ] || q_s[DQ] > LIM) ? LIM : q_s[DQ];
	assign phi = neg_s[DQ] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

>>> hdl/dmsu_hyp_exp.sv
// Range reduction by ln2 and hyperbolic CORDIC: e^r, e^-r and k for phi.
module dmsu_hyp_exp #(
	parameter int FRAC_BITS   = 20,
	parameter int HYPER_ITERS = 24
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [FRAC_BITS+6:0]          phi,
	output logic signed [dmsu_pkg::EXP_W-1:0]    ep,
	output logic signed [dmsu_pkg::EXP_W-1:0]    em,
	output logic signed [dmsu_pkg::K_W-1:0]      k
);
	import dmsu_pkg::*;

	localparam int SW = 38;          // reduction word
	localparam int KB = 7;           // quotient bits of phi/ln2
	localparam int XW = EXP_W - 1;
	localparam int ZW = 34;
	localparam logic [SW-1:0]        LN2W = SW'(LN2_Q30);
	localparam logic signed [XW-1:0] X0   = XW'(hyp_x0(HYPER_ITERS));
	localparam sh_tab_t SHT = hyp_shift_tab();
	localparam at_tab_t ATT = hyp_atanh_tab();

	logic signed [SW-1:0] p30;
	logic signed [SW-1:0] num;
	logic [SW-1:0]        rm_s [KB+1];
	logic [KB-1:0]        kq_s [KB+1];
	logic                 ng_s [KB+1];

	logic signed [XW-1:0]  x_s [HYPER_ITERS+1];
	logic signed [XW-1:0]  y_s [HYPER_ITERS+1];
	logic signed [ZW-1:0]  z_s [HYPER_ITERS+1];
	logic signed [K_W-1:0] k_s [HYPER_ITERS+1];

	logic                  nz;
	logic [30:0]           t_frac;
	logic signed [ZW-1:0]  r_val;
	logic signed [K_W-1:0] k_val;

	assign p30 = SW'(phi) <<< (CQ - FRAC_BITS);
	assign num = p30 + SW'(LN2_HALF);

	// floor division fix-up: negative operand with a remainder rounds away
	always_comb begin
		nz     = rm_s[KB] != '0;
		t_frac = 31'(rm_s[KB]);
		k_val  = K_W'(kq_s[KB]);
		if (ng_s[KB]) begin
			t_frac = nz ? 31'(LN2W - rm_s[KB]) : '0;
			k_val  = -(K_W'(kq_s[KB]) + K_W'(nz));
		end
		r_val = $signed(ZW'(t_frac)) - ZW'(LN2_HALF);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ng_s[0] <= num < 0;
			rm_s[0] <= (num < 0) ? SW'(-num) : SW'(num);
			kq_s[0] <= '0;
			for (int j = 1; j <= KB; j++) begin
				if (rm_s[j-1] >= (LN2W << (KB - j))) begin
					rm_s[j] <= rm_s[j-1] - (LN2W << (KB - j));
					kq_s[j] <= kq_s[j-1] | (KB'(1) << (KB - j));
				end else begin
					rm_s[j] <= rm_s[j-1];
					kq_s[j] <= kq_s[j-1];
				end
				ng_s[j] <= ng_s[j-1];
			end

			x_s[0] <= X0;
			y_s[0] <= '0;
			z_s[0] <= r_val;
			k_s[0] <= k_val;
			for (int c = 1; c <= HYPER_ITERS; c++) begin
				if (z_s[c-1] >= 0) begin
					x_s[c] <= x_s[c-1] + (y_s[c-1] >>> SHT[c-1]);
					y_s[c] <= y_s[c-1] + (x_s[c-1] >>> SHT[c-1]);
					z_s[c] <= z_s[c-1] - $signed({3'b000, ATT[c-1]});
				end else begin
					x_s[c] <= x_s[c-1] - (y_s[c-1] >>> SHT[c-1]);
					y_s[c] <= y_s[c-1] - (x_s[c-1] >>> SHT[c-1]);
					z_s[c] <= z_s[c-1] + $signed({3'b000, ATT[c-1]});
				end
				k_s[c] <= k_s[c-1];
			end
		end
	end

	assign ep = EXP_W'(x_s[HYPER_ITERS]) + EXP_W'(y_s[HYPER_ITERS]);
	assign em = EXP_W'(x_s[HYPER_ITERS]) - EXP_W'(y_s[HYPER_ITERS]);
	assign k  = k_s[HYPER_ITERS];

endmodule

>>> hdl/density_magnetization_stencil_update.sv
// Top level: explicit five-point stencil update of density and magnetization for one cell.
// Throughput: one request per cycle; the whole pipeline advances together and stalls
//   only while a finished result waits at the output register.
// Depth is set mainly by the divider (FRAC_BITS + 6 stages) and the CORDIC (HYPER_ITERS stages).
// Reset clears the four coefficient registers and all valid bits; payload is not reset.
module density_magnetization_stencil_update #(
	parameter int FRAC_BITS   = 20,
	parameter int HYPER_ITERS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dmsu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dmsu_pkg::WORD_W-1:0]          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [31:0]                   rho_center,
	input  logic signed [31:0]                   rho_west,
	input  logic signed [31:0]                   rho_east,
	input  logic signed [31:0]                   rho_south,
	input  logic signed [31:0]                   rho_north,
	input  logic signed [31:0]                   mag_center,
	input  logic signed [31:0]                   mag_west,
	input  logic signed [31:0]                   mag_east,
	input  logic signed [31:0]                   mag_south,
	input  logic signed [31:0]                   mag_north,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [31:0]                   rho_next,
	output logic signed [31:0]                   mag_next,
	output logic [1:0]                           status
);
	import dmsu_pkg::*;

	localparam int DQ  = FRAC_BITS + 6;
	localparam int TE  = DQ + HYPER_ITERS + 9;  // side slot aligned with CORDIC outputs
	localparam int TM  = TE + 1;                // product stage
	localparam int NS  = TM + 3;                // side slots 0 .. TM+2
	localparam int LW  = 69;                    // linear-term width
	localparam int PAW = 70;                    // reaction half-product width
	localparam logic signed [PAW-1:0] HALF_LIM  = PAW'({1'b1, 40'b0});
	localparam logic signed [PAW:0]   REACT_LIM = (PAW + 1)'({1'b1, 34'b0});
	localparam logic signed [69:0]    OMAX = 70'sh7fffffff;
	localparam logic signed [69:0]    OMIN = -70'sh80000000;

	typedef struct packed {
		logic signed [LW-1:0] rho_lin;
		logic signed [LW-1:0] mag_lin;
		logic signed [31:0]   rc;
		logic signed [31:0]   mc;
		logic                 pos;
	} side_t;

	// coefficient registers
	logic signed [31:0] adv_q, dif_q, beta_q, gam_q;

	// pipeline control
	logic en;
	logic v_s1;
	logic vld_s [NS];
	logic out_valid_q;

	// stage 1: differences, Laplacians, B*m
	logic signed [31:0] rc_s1, mc_s1;
	logic signed [32:0] dm_s1, dr_s1;
	logic signed [34:0] lr_s1, lm_s1;
	logic signed [63:0] bm_s1;
	logic               pos_s1;

	// stage 2: coefficient products
	logic signed [64:0] pam, par;
	logic signed [66:0] pdr, pdm;
	side_t              side_in;
	side_t              side_s [NS];

	// divider / exponential
	logic signed [FRAC_BITS+6:0] phi;
	logic signed [EXP_W-1:0]     ep, em;
	logic signed [K_W-1:0]       k_e;

	// reaction term stages
	logic signed [PAW-1:0] pa_s5, pb_s5;
	logic signed [K_W-1:0] k_s5;
	logic signed [PAW-1:0] ha, hb;
	logic signed [PAW:0]   hdiff;
	logic signed [35:0]    react_s6;
	logic signed [67:0]    gp;
	logic signed [67:0]    gt_s7;

	// output stage
	side_t              fin;
	logic signed [69:0] rho_new, mag_new;
	logic               sat;
	logic signed [31:0] rho_next_q, mag_next_q;
	status_t            status_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_q  <= '0;
			dif_q  <= '0;
			beta_q <= '0;
			gam_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ADVECTION: adv_q  <= cfg_data;
				CFG_DIFFUSION: dif_q  <= cfg_data;
				CFG_INV_TEMP:  beta_q <= cfg_data;
				CFG_REACTION:  gam_q  <= cfg_data;
				default:       ;
			endcase
		end
	end

	// ---------------- valid line ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int t = 0; t < NS; t++)
				vld_s[t] <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			vld_s[0] <= v_s1;
			for (int t = 1; t < NS; t++)
				vld_s[t] <= vld_s[t-1];
			out_valid_q <= vld_s[NS-1];
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			rc_s1  <= rho_center;
			mc_s1  <= mag_center;
			dm_s1  <= 33'(mag_east) - 33'(mag_west);
			dr_s1  <= 33'(rho_east) - 33'(rho_west);
			lr_s1  <= 35'(rho_west) + 35'(rho_east) + 35'(rho_south) + 35'(rho_north)
			          - (35'(rho_center) <<< 2);
			lm_s1  <= 35'(mag_west) + 35'(mag_east) + 35'(mag_south) + 35'(mag_north)
			          - (35'(mag_center) <<< 2);
			bm_s1  <= beta_q * mag_center;
			pos_s1 <= rho_center > 0;
		end
	end

	// ---------------- stage 2: advection and diffusion ----------------
	always_comb begin
		pam = adv_q * dm_s1;
		par = adv_q * dr_s1;
		pdr = dif_q * lr_s1;
		pdm = dif_q * lm_s1;
		side_in.rho_lin = LW'(rc_s1) - LW'(pam >>> FRAC_BITS) + LW'(pdr >>> FRAC_BITS);
		side_in.mag_lin = LW'(mc_s1) - LW'(par >>> FRAC_BITS) + LW'(pdm >>> FRAC_BITS);
		side_in.rc      = rc_s1;
		side_in.mc      = mc_s1;
		side_in.pos     = pos_s1;
	end

	// side data rides alongside the divider and CORDIC
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int t = 1; t < NS; t++)
				side_s[t] <= side_s[t-1];
		end
	end

	// ---------------- phi = B*m/rho and exponentials ----------------
	dmsu_phi_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.en      (en),
		.num_mag (bm_s1[63] ? 63'(-bm_s1) : bm_s1[62:0]),
		.num_neg (bm_s1[63]),
		.dvs     (pos_s1 ? rc_s1[30:0] : 31'd1),
		.phi     (phi)
	);

	dmsu_hyp_exp #(
		.FRAC_BITS   (FRAC_BITS),
		.HYPER_ITERS (HYPER_ITERS)
	) u_exp (
		.clk (clk),
		.en  (en),
		.phi (phi),
		.ep  (ep),
		.em  (em),
		.k   (k_e)
	);

	// ---------------- reaction term ----------------
	// v * 2^-s, floor on the way down, saturating to +-2^40 on the way up
	function automatic logic signed [PAW-1:0] scale_half(
		input logic signed [PAW-1:0] v,
		input logic signed [8:0]     s
	);
		logic [3:0]            sh;
		logic signed [PAW-1:0] bound;
		logic signed [PAW-1:0] res;
		sh    = 4'(-s);
		bound = HALF_LIM >>> sh;
		if (s >= 0)
			res = v >>> s;
		else if (v > bound)
			res = HALF_LIM;
		else if (v < -bound)
			res = -HALF_LIM;
		else
			res = v <<< sh;
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s5 <= (33'(side_s[TE].rc) - 33'(side_s[TE].mc)) * ep;
			pb_s5 <= (33'(side_s[TE].rc) + 33'(side_s[TE].mc)) * em;
			k_s5  <= k_e;
		end
	end

	always_comb begin
		ha    = scale_half(pa_s5, 9'(CQ + 1) - 9'(k_s5));
		hb    = scale_half(pb_s5, 9'(CQ + 1) + 9'(k_s5));
		hdiff = (PAW + 1)'(ha) - (PAW + 1)'(hb);
		gp    = gam_q * react_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (hdiff > REACT_LIM)
				react_s6 <= 36'(REACT_LIM);
			else if (hdiff < -REACT_LIM)
				react_s6 <= -36'(REACT_LIM);
			else
				react_s6 <= 36'(hdiff);
			gt_s7 <= gp >>> FRAC_BITS;
		end
	end

	// ---------------- final sum, saturation, status ----------------
	always_comb begin
		fin     = side_s[NS-1];
		rho_new = 70'(fin.rho_lin);
		mag_new = 70'(fin.mag_lin) + (fin.pos ? 70'(gt_s7) : 70'sd0);
		sat     = rho_new > OMAX || rho_new < OMIN || mag_new > OMAX || mag_new < OMIN;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rho_next_q <= (rho_new > OMAX) ? 32'sh7fffffff :
			              (rho_new < OMIN) ? 32'sh80000000 : 32'(rho_new);
			mag_next_q <= (mag_new > OMAX) ? 32'sh7fffffff :
			              (mag_new < OMIN) ? 32'sh80000000 : 32'(mag_new);
			status_q   <= !fin.pos ? ST_NONPOS : (sat ? ST_SAT : ST_OK);
		end
	end

	assign out_valid = out_valid_q;
	assign rho_next  = rho_next_q;
	assign mag_next  = mag_next_q;
	assign status    = status_q;

	// ---------------- assertions ----------------
	a_stall_holds_valids: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (vld_s[0] == $past(vld_s[0])) && (vld_s[NS-1] == $past(vld_s[NS-1])))
		else $error("valid line moved during a stall");

	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted request did not enter stage 1");

	a_sat_means_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SAT |->
			(rho_next == 32'sh7fffffff || rho_next == 32'sh80000000 ||
			 mag_next == 32'sh7fffffff || mag_next == 32'sh80000000))
		else $error("saturation status without a railed result");

endmodule
